/* sv/tslink_pkg.sv */
// tslink_pkg: widths, reset values, character codes and register indexes
// for the tagged sensor link decoder; no dependencies
`default_nettype none

package tslink_pkg;

    // channel widths
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 120;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // payload field widths
    localparam int RX_W  = 8;
    localparam int RAW_W = 16;
    localparam int MA_W  = 32;
    localparam int MV_W  = 32;

    // configuration register widths
    localparam int SENS_W = 10;
    localparam int OFS_W  = 13;
    localparam int REF_W  = 16;
    localparam int RES_W  = 20;
    localparam int VMIN_W = 16;
    localparam int DROP_W = 8;
    localparam int THR_W  = 17;

    // configuration reset values
    localparam logic [SENS_W-1:0]        SENS_RST = 10'd185;
    localparam logic [OFS_W-1:0]         OFS_RST  = 13'd2500;
    localparam logic [REF_W-1:0]         REF_RST  = 16'd5000;
    localparam logic [RES_W-1:0]         TOP_RST  = 20'd30000;
    localparam logic [RES_W-1:0]         BOT_RST  = 20'd7000;
    localparam logic signed [VMIN_W-1:0] VMIN_RST = 16'sd100;
    localparam logic [DROP_W-1:0]        DROP_RST = 8'd5;
    localparam logic [THR_W-1:0]         THR_RST  = 17'd400;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VMIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DROP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THR  = 3'd7;

    // beat kinds on s_tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // character codes
    localparam logic [RX_W-1:0] CH_Q     = 8'h71;
    localparam logic [RX_W-1:0] CH_J     = 8'h6A;
    localparam logic [RX_W-1:0] CH_W     = 8'h77;
    localparam logic [RX_W-1:0] CH_SPACE = 8'h20;
    localparam logic [RX_W-1:0] CH_TAB   = 8'h09;
    localparam logic [RX_W-1:0] CH_CR    = 8'h0D;
    localparam logic [RX_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [RX_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [RX_W-1:0] CH_0     = 8'h30;
    localparam logic [RX_W-1:0] CH_9     = 8'h39;

    // arithmetic constants
    localparam int MILLI      = 1000;
    localparam int SCALE_SH   = 10;
    localparam int DIV_STEPS  = 32;
    localparam int MAG_SAT    = 32768;

endpackage

`default_nettype wire

/* sv/tagged_sensor_link_decoder.sv */
// tagged_sensor_link_decoder: serial decimal parser with tag latching and a
// tick-driven current / battery conversion on one shared multiplier and divider
// depends on tslink_pkg
//
//  port group  dir  beat contents (lsb first)
//  s_          in   tdata: rx_byte; tuser: cmd
//  m_          out  tdata: raw_current, raw_voltage, rain_value, current_ma,
//                          battery_mv, charging, zero fill
//  cfg_        in   write strobe, register index, data (low bits kept)
//
// byte beat: result is loaded at the accepting edge and shows on the next cycle
// tick beat: five multiply steps, then up to two 32-step passes of the shared
//   restoring divider (current, then voltage)
// s_tready is high only when idle and the output register is free or being taken
// a stalled result holds in the output register; reset is synchronous, active low,
//   and restores the register defaults with no clearing pass
`default_nettype none

module tagged_sensor_link_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tslink_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [tslink_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] cmd
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] raw_current, [31:16] raw_voltage, [47:32] rain_value,
    // [79:48] current_ma, [111:80] battery_mv, [112] charging, [119:113] zero
    output logic [tslink_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [tslink_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tslink_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tslink_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_RAW = 4'd1;
    localparam logic [3:0] ST_MUL_K   = 4'd2;
    localparam logic [3:0] ST_MUL_OFS = 4'd3;
    localparam logic [3:0] ST_SUB     = 4'd4;
    localparam logic [3:0] ST_MUL_SUM = 4'd5;
    localparam logic [3:0] ST_DIV_C   = 4'd6;
    localparam logic [3:0] ST_C_END   = 4'd7;
    localparam logic [3:0] ST_DIV_V   = 4'd8;
    localparam logic [3:0] ST_V_END   = 4'd9;

    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    localparam int MAG_W   = 16;
    localparam int MAGX_W  = 19;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = 55;
    localparam int ACC_W   = 44;
    localparam int VN_W    = 53;
    localparam int Q_W     = 32;
    localparam int R_W     = 20;
    localparam int HI_W    = VN_W - SCALE_SH - Q_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);
    localparam int PAD_W   = M_TDATA_W - 3 * RAW_W - MA_W - MV_W - 1;

    localparam logic [Q_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [MV_W-1:0] U32_MAX = 32'hFFFF_FFFF;

    // configuration registers
    logic [SENS_W-1:0]        sens_reg;
    logic [OFS_W-1:0]         ofs_reg;
    logic [REF_W-1:0]         ref_reg;
    logic [RES_W-1:0]         top_reg;
    logic [RES_W-1:0]         bot_reg;
    logic signed [VMIN_W-1:0] vmin_reg;
    logic [DROP_W-1:0]        drop_lim_reg;
    logic [THR_W-1:0]         thr_reg;

    // control and result state
    logic [3:0]              state_reg,    state_next;
    logic [1:0]              phase_reg,    phase_next;
    logic                    pneg_reg,     pneg_next;
    logic [MAG_W-1:0]        mag_reg,      mag_next;
    logic signed [RAW_W-1:0] cur_raw_reg,  cur_raw_next;
    logic signed [RAW_W-1:0] volt_raw_reg, volt_raw_next;
    logic signed [RAW_W-1:0] rain_reg,     rain_next;
    logic [MV_W-1:0]         good_reg,     good_next;
    logic [DROP_W-1:0]       drop_reg,     drop_next;
    logic [MA_W-1:0]         cur_ma_reg,   cur_ma_next;
    logic [MV_W-1:0]         batt_reg,     batt_next;
    logic                    chg_reg,      chg_next;
    logic                    out_vld_reg,  out_vld_next;
    logic [M_TDATA_W-1:0]    out_reg,      out_next;

    // shared datapath
    logic signed [PROD_W-1:0] prod_reg,    prod_next;
    logic signed [ACC_W-1:0]  acc_reg,     acc_next;
    logic [Q_W-1:0]           quo_reg,     quo_next;
    logic [R_W-1:0]           rem_reg,     rem_next;
    logic [R_W-1:0]           dvsr_reg,    dvsr_next;
    logic [SCALE_SH-1:0]      low_reg,     low_next;
    logic [CNT_W-1:0]         cnt_reg,     cnt_next;

    logic                      in_beat;
    logic                      out_beat;
    logic [RX_W-1:0]           rx;
    logic                      is_digit;
    logic                      is_space;
    logic [3:0]                digit_val;
    logic [MAGX_W-1:0]         mag_x10;
    logic [MAG_W-1:0]          mag_sat;
    logic signed [RAW_W-1:0]   latch_val;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [ACC_W-1:0]          acc_abs;
    logic [R_W:0]              div_top;
    logic                      div_ge;
    logic [R_W:0]              div_diff;
    logic [R_W-1:0]            rem_step;
    logic [Q_W-1:0]            quo_step;
    logic                      c_neg;
    logic                      c_nz;
    logic [Q_W-1:0]            thr_ext;
    logic                      v_valid;
    logic                      v_pos;
    logic [HI_W-1:0]           vn_hi;
    logic [Q_W-1:0]            vn_lo;
    logic                      vn_zero;
    logic                      v_sat;
    logic [DROP_W-1:0]         drop_inc;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg     <= SENS_RST;
            ofs_reg      <= OFS_RST;
            ref_reg      <= REF_RST;
            top_reg      <= TOP_RST;
            bot_reg      <= BOT_RST;
            vmin_reg     <= VMIN_RST;
            drop_lim_reg <= DROP_RST;
            thr_reg      <= THR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SENS: sens_reg     <= cfg_data[SENS_W-1:0];
                REG_OFS:  ofs_reg      <= cfg_data[OFS_W-1:0];
                REG_REF:  ref_reg      <= cfg_data[REF_W-1:0];
                REG_TOP:  top_reg      <= cfg_data[RES_W-1:0];
                REG_BOT:  bot_reg      <= cfg_data[RES_W-1:0];
                REG_VMIN: vmin_reg     <= $signed(cfg_data[VMIN_W-1:0]);
                REG_DROP: drop_lim_reg <= cfg_data[DROP_W-1:0];
                REG_THR:  thr_reg      <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && (!out_vld_reg || m_tready);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = out_vld_reg && m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // character classes and digit accumulation
    assign rx        = s_tdata[RX_W-1:0];
    assign is_digit  = (rx >= CH_0) && (rx <= CH_9);
    assign is_space  = (rx == CH_SPACE) || ((rx >= CH_TAB) && (rx <= CH_CR));
    assign digit_val = 4'(rx - CH_0);
    assign mag_x10   = MAGX_W'(mag_reg) * MAGX_W'(10) + MAGX_W'(digit_val);
    assign mag_sat   = (mag_x10 > MAGX_W'(MAG_SAT)) ? MAG_W'(MAG_SAT) : mag_x10[MAG_W-1:0];
    assign latch_val = pneg_reg ? $signed(MAG_W'(0) - mag_reg)
                     : ((mag_reg > MAG_W'(MAG_SAT - 1)) ? RAW_W'(16'sh7FFF)
                                                         : $signed(mag_reg));

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_RAW: begin
                mul_a = MUL_A_W'(cur_raw_reg);
                mul_b = MUL_B_W'(ref_reg);
            end
            ST_MUL_K: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(MILLI);
            end
            ST_MUL_OFS: begin
                mul_a = $signed(MUL_A_W'(ofs_reg));
                mul_b = MUL_B_W'(MILLI);
            end
            ST_SUB: begin
                mul_a = MUL_A_W'(volt_raw_reg);
                mul_b = MUL_B_W'(ref_reg);
            end
            ST_MUL_SUM: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(top_reg) + MUL_B_W'(bot_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // one restoring divide step per cycle
    assign div_top  = {rem_reg, quo_reg[Q_W-1]};
    assign div_ge   = div_top >= {1'b0, dvsr_reg};
    assign div_diff = div_top - {1'b0, dvsr_reg};
    assign rem_step = div_ge ? div_diff[R_W-1:0] : div_top[R_W-1:0];
    assign quo_step = {quo_reg[Q_W-2:0], div_ge};

    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign c_neg   = acc_reg[ACC_W-1];
    assign c_nz    = |acc_reg;
    assign thr_ext = Q_W'(thr_reg);

    assign v_valid  = volt_raw_reg > $signed(vmin_reg);
    assign v_pos    = volt_raw_reg > $signed(RAW_W'(0));
    assign vn_hi    = prod_reg[VN_W-1 -: HI_W];
    assign vn_lo    = prod_reg[SCALE_SH +: Q_W];
    assign vn_zero  = ~|prod_reg[VN_W-1:0];
    // a quotient of 2^32 or more shows as the top bits already reaching the divisor
    assign v_sat    = R_W'(vn_hi) >= bot_reg;
    assign drop_inc = (drop_reg == {DROP_W{1'b1}}) ? drop_reg : drop_reg + DROP_W'(1);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pneg_next     = pneg_reg;
        mag_next      = mag_reg;
        cur_raw_next  = cur_raw_reg;
        volt_raw_next = volt_raw_reg;
        rain_next     = rain_reg;
        good_next     = good_reg;
        drop_next     = drop_reg;
        cur_ma_next   = cur_ma_reg;
        batt_next     = batt_reg;
        chg_next      = chg_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvsr_next     = dvsr_reg;
        low_next      = low_reg;
        cnt_next      = cnt_reg;
        out_vld_next  = out_beat ? 1'b0 : out_vld_reg;
        out_next      = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_tuser[0] == CMD_TICK) begin
                        state_next = ST_MUL_RAW;
                    end else begin
                        if (rx == CH_Q || rx == CH_J || rx == CH_W) begin
                            if (rx == CH_Q) cur_raw_next = latch_val;
                            if (rx == CH_J) volt_raw_next = latch_val;
                            if (rx == CH_W) rain_next = latch_val;
                            phase_next = PH_LEAD;
                            pneg_next  = 1'b0;
                            mag_next   = '0;
                        end else if (phase_reg == PH_LEAD && is_space) begin
                            phase_next = PH_LEAD;
                        end else if (phase_reg == PH_LEAD &&
                                     (rx == CH_PLUS || rx == CH_MINUS)) begin
                            pneg_next  = (rx == CH_MINUS);
                            phase_next = PH_SIGN;
                        end else if (phase_reg != PH_END && is_digit) begin
                            mag_next   = mag_sat;
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_END;
                        end
                        out_vld_next = 1'b1;
                    end
                end
            end
            ST_MUL_RAW: begin
                prod_next  = mul_p;
                state_next = ST_MUL_K;
            end
            ST_MUL_K: begin
                prod_next  = mul_p;
                state_next = ST_MUL_OFS;
            end
            ST_MUL_OFS: begin
                acc_next   = prod_reg[ACC_W-1:0];
                prod_next  = mul_p;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                // offset term: offset*1000 scaled by 1024
                acc_next   = acc_reg - $signed({prod_reg[ACC_W-SCALE_SH-1:0],
                                                {SCALE_SH{1'b0}}});
                prod_next  = mul_p;
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                prod_next  = mul_p;
                quo_next   = acc_abs[SCALE_SH +: Q_W];
                low_next   = acc_abs[SCALE_SH-1:0];
                rem_next   = '0;
                dvsr_next  = R_W'(sens_reg);
                cnt_next   = '0;
                state_next = (sens_reg == '0) ? ST_C_END : ST_DIV_C;
            end
            ST_DIV_C: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_C_END;
            end
            ST_C_END: begin
                if (sens_reg == '0) begin
                    cur_ma_next = c_neg ? S32_MIN : (c_nz ? S32_MAX : '0);
                    chg_next    = !c_neg && c_nz;
                end else begin
                    if (!c_neg)
                        cur_ma_next = quo_reg[Q_W-1] ? S32_MAX : quo_reg;
                    else
                        cur_ma_next = (quo_reg > S32_MIN) ? S32_MIN : Q_W'(-quo_reg);
                    chg_next = !c_neg && ((quo_reg > thr_ext) ||
                               ((quo_reg == thr_ext) && ((|rem_reg) || (|low_reg))));
                end
                state_next = ST_IDLE;
                if (!v_valid) begin
                    drop_next    = drop_inc;
                    batt_next    = (drop_inc > drop_lim_reg) ? '0 : good_reg;
                    out_vld_next = 1'b1;
                end else if (!v_pos || (v_sat && vn_zero)) begin
                    batt_next    = '0;
                    good_next    = '0;
                    drop_next    = '0;
                    out_vld_next = 1'b1;
                end else if (v_sat) begin
                    batt_next    = U32_MAX;
                    good_next    = U32_MAX;
                    drop_next    = '0;
                    out_vld_next = 1'b1;
                end else begin
                    quo_next   = vn_lo;
                    rem_next   = R_W'(vn_hi);
                    dvsr_next  = bot_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_V_END;
            end
            ST_V_END: begin
                batt_next    = quo_reg;
                good_next    = quo_reg;
                drop_next    = '0;
                out_vld_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_vld_next && !(out_vld_reg && !out_beat))
            out_next = {PAD_W'(0), chg_next, batt_next, cur_ma_next,
                        rain_next, volt_raw_next, cur_raw_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_LEAD;
            pneg_reg     <= 1'b0;
            mag_reg      <= '0;
            cur_raw_reg  <= '0;
            volt_raw_reg <= '0;
            rain_reg     <= '0;
            good_reg     <= '0;
            drop_reg     <= '0;
            cur_ma_reg   <= '0;
            batt_reg     <= '0;
            chg_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            pneg_reg     <= pneg_next;
            mag_reg      <= mag_next;
            cur_raw_reg  <= cur_raw_next;
            volt_raw_reg <= volt_raw_next;
            rain_reg     <= rain_next;
            good_reg     <= good_next;
            drop_reg     <= drop_next;
            cur_ma_reg   <= cur_ma_next;
            batt_reg     <= batt_next;
            chg_reg      <= chg_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        low_reg  <= low_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

/* sv/tslink_checker.sv */
// tslink_checker: port-level checks on the tagged sensor link decoder,
// bound to the top level; depends on tslink_pkg
`default_nettype none

module tslink_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [tslink_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tslink_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tslink_pkg::*;

    // a held result keeps its beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input is only taken when the output slot can take the answer
    a_ready_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input ready with output slot blocked");

    // a byte beat answers on the next cycle
    a_byte_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_BYTE |=> m_tvalid)
        else $error("byte beat gave no result");

    // a tick keeps the block busy
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_TICK |=> !s_tready && !m_tvalid)
        else $error("tick beat did not start a conversion");

endmodule

bind tagged_sensor_link_decoder tslink_checker u_tslink_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for the tagged sensor link decoder; an in-bench
// model of the parser and the tick conversion predicts every output beat
// depends on tslink_pkg and tagged_sensor_link_decoder

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tslink_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 100;

    localparam longint MA_MAX = 64'sd2147483647;
    localparam longint MA_MIN = -64'sd2147483648;
    localparam longint MV_MAX = 64'sd4294967295;

    typedef enum logic [1:0] {PH_LEAD, PH_SIGNED, PH_DIGITS, PH_DONE} parse_phase_t;

    typedef struct {
        logic signed [RAW_W-1:0] raw_current;
        logic signed [RAW_W-1:0] raw_voltage;
        logic signed [RAW_W-1:0] rain;
        logic signed [MA_W-1:0]  current_ma;
        logic [MV_W-1:0]         battery_mv;
        logic                    charging;
    } reading_t;

    class reading_scoreboard;
        logic [SENS_W-1:0]        sens;
        logic [OFS_W-1:0]         ofs;
        logic [REF_W-1:0]         adc_ref;
        logic [RES_W-1:0]         top;
        logic [RES_W-1:0]         bot;
        logic signed [VMIN_W-1:0] vmin;
        logic [DROP_W-1:0]        drop_lim;
        logic [THR_W-1:0]         thr;

        parse_phase_t phase;
        bit           negative;
        int unsigned  magnitude;
        reading_t     now;
        logic [MV_W-1:0]   last_good;
        logic [DROP_W-1:0] drop_count;

        reading_t    pending[$];
        int unsigned errors;
        int unsigned results;
        int unsigned bytes_seen;
        int unsigned ticks_seen;

        function new();
            sens = SENS_RST;
            ofs = OFS_RST;
            adc_ref = REF_RST;
            top = TOP_RST;
            bot = BOT_RST;
            vmin = VMIN_RST;
            drop_lim = DROP_RST;
            thr = THR_RST;
            phase = PH_LEAD;
            negative = 0;
            magnitude = 0;
            now = '{default: 0};
            last_good = '0;
            drop_count = '0;
            errors = 0;
            results = 0;
            bytes_seen = 0;
            ticks_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_SENS: sens = d[SENS_W-1:0];
                REG_OFS:  ofs = d[OFS_W-1:0];
                REG_REF:  adc_ref = d[REF_W-1:0];
                REG_TOP:  top = d[RES_W-1:0];
                REG_BOT:  bot = d[RES_W-1:0];
                REG_VMIN: vmin = d[VMIN_W-1:0];
                REG_DROP: drop_lim = d[DROP_W-1:0];
                REG_THR:  thr = d[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // tag seen: saturate to the 16 bit range and restart the parser
        function logic signed [RAW_W-1:0] latched();
            int m;
            int v;
            m = int'(magnitude);
            if (negative)
                v = (m > MAG_SAT) ? -MAG_SAT : -m;
            else
                v = (m > MAG_SAT - 1) ? MAG_SAT - 1 : m;
            phase = PH_LEAD;
            negative = 0;
            magnitude = 0;
            return v[RAW_W-1:0];
        endfunction

        function void take_char(logic [RX_W-1:0] c);
            if (c == CH_Q) begin
                now.raw_current = latched();
                return;
            end
            if (c == CH_J) begin
                now.raw_voltage = latched();
                return;
            end
            if (c == CH_W) begin
                now.rain = latched();
                return;
            end
            if (phase == PH_LEAD) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    return;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    negative = (c == CH_MINUS);
                    phase = PH_SIGNED;
                    return;
                end
            end
            if (phase != PH_DONE && c >= CH_0 && c <= CH_9) begin
                magnitude = magnitude * 10 + (c - CH_0);
                if (magnitude > MAG_SAT)
                    magnitude = MAG_SAT;
                phase = PH_DIGITS;
                return;
            end
            // anything else ends the number; later digits are ignored
            phase = PH_DONE;
        endfunction

        function void run_tick();
            longint num;
            longint den;
            longint q;
            longint vn;
            longint vd;
            longint mv;
            num = longint'(now.raw_current) * longint'(adc_ref) * MILLI
                - longint'(ofs) * 1024 * MILLI;
            den = longint'(sens) * 1024;
            if (den == 0) begin
                q = (num > 0) ? MA_MAX : ((num < 0) ? MA_MIN : 0);
                now.charging = (num > 0);
            end else begin
                q = num / den;
                now.charging = (num > longint'(thr) * den);
            end
            if (q > MA_MAX)
                q = MA_MAX;
            if (q < MA_MIN)
                q = MA_MIN;
            now.current_ma = q[MA_W-1:0];

            if (now.raw_voltage > vmin) begin
                vn = longint'(now.raw_voltage) * longint'(adc_ref)
                   * (longint'(top) + longint'(bot));
                vd = longint'(bot) * 1024;
                if (vd == 0)
                    mv = (vn > 0) ? MV_MAX : 0;
                else
                    mv = vn / vd;
                if (mv < 0)
                    mv = 0;
                if (mv > MV_MAX)
                    mv = MV_MAX;
                now.battery_mv = mv[MV_W-1:0];
                last_good = now.battery_mv;
                drop_count = '0;
            end else begin
                // hold the last good voltage until the dropout count runs past its limit
                now.battery_mv = last_good;
                if (drop_count != '1)
                    drop_count++;
                if (drop_count > drop_lim)
                    now.battery_mv = '0;
            end
        endfunction

        function void note_beat(logic cmd, logic [RX_W-1:0] c);
            if (cmd == CMD_TICK) begin
                ticks_seen++;
                run_tick();
            end else begin
                bytes_seen++;
                take_char(c);
            end
            pending.push_back(now);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            reading_t want;
            results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: output beat %h with no reading expected, actual", $time, d);
                return;
            end
            want = pending.pop_front();
            compare_field("raw_current", $unsigned(want.raw_current), d[RAW_W-1:0]);
            compare_field("raw_voltage", $unsigned(want.raw_voltage), d[2*RAW_W-1:RAW_W]);
            compare_field("rain_value", $unsigned(want.rain), d[3*RAW_W-1:2*RAW_W]);
            compare_field("current_ma", $unsigned(want.current_ma),
                          d[3*RAW_W+MA_W-1:3*RAW_W]);
            compare_field("battery_mv", want.battery_mv,
                          d[3*RAW_W+MA_W+MV_W-1:3*RAW_W+MA_W]);
            compare_field("charging", want.charging, d[3*RAW_W+MA_W+MV_W]);
            compare_field("zero fill", 0, d[M_TDATA_W-1:3*RAW_W+MA_W+MV_W+1]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    reading_scoreboard     sb;
    logic [CFG_DATA_W-1:0] cfg_vals [8];
    int unsigned           beats_sent = 0;
    int unsigned           cfg_loads = 0;
    int unsigned           send_burst = 0;
    int unsigned           idle_cycles = 0;

    tagged_sensor_link_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int unsigned pick_gap(inout int unsigned burst);
        int unsigned r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    initial begin
        int unsigned hold;
        int unsigned burst;
        burst = 0;
        forever begin
            hold = pick_gap(burst);
            if (hold > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // valid is left high after the accepting edge so back-to-back beats need one assignment
    task automatic send_beat(input logic cmd, input logic [RX_W-1:0] c);
        int unsigned gap;
        gap = pick_gap(send_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_digits(input int unsigned m);
        logic [RX_W-1:0] digs[$];
        do begin
            digs.push_front(CH_0 + RX_W'(m % 10));
            m = m / 10;
        end while (m != 0);
        foreach (digs[i])
            send_beat(CMD_BYTE, digs[i]);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_beat(CMD_TICK, RX_W'($urandom));
    endtask

    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config();
        for (int i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= cfg_vals[i];
            @(posedge aclk);
            sb.write_reg(CFG_IDX_W'(i), cfg_vals[i]);
        end
        @(negedge aclk) cfg_we <= 1'b0;
        cfg_loads++;
    endtask

    function automatic void set_defaults();
        cfg_vals[REG_SENS] = CFG_DATA_W'(SENS_RST);
        cfg_vals[REG_OFS]  = CFG_DATA_W'(OFS_RST);
        cfg_vals[REG_REF]  = CFG_DATA_W'(REF_RST);
        cfg_vals[REG_TOP]  = CFG_DATA_W'(TOP_RST);
        cfg_vals[REG_BOT]  = CFG_DATA_W'(BOT_RST);
        cfg_vals[REG_VMIN] = CFG_DATA_W'(16'(VMIN_RST));
        cfg_vals[REG_DROP] = CFG_DATA_W'(DROP_RST);
        cfg_vals[REG_THR]  = CFG_DATA_W'(THR_RST);
    endfunction

    function automatic void random_config();
        int v;
        cfg_vals[REG_SENS] = ($urandom_range(0, 19) == 0) ? '0
                                                          : CFG_DATA_W'($urandom_range(1, 1000));
        cfg_vals[REG_OFS]  = CFG_DATA_W'($urandom_range(0, 5000));
        cfg_vals[REG_REF]  = CFG_DATA_W'($urandom_range(1, 65535));
        cfg_vals[REG_TOP]  = CFG_DATA_W'($urandom_range(0, 1000000));
        cfg_vals[REG_BOT]  = ($urandom_range(0, 19) == 0) ? '0
                                                          : CFG_DATA_W'($urandom_range(1, 1000000));
        v = int'($urandom_range(0, 600)) - 300;
        cfg_vals[REG_VMIN] = CFG_DATA_W'(v[15:0]);
        cfg_vals[REG_DROP] = CFG_DATA_W'($urandom_range(0, 8));
        cfg_vals[REG_THR]  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 131071))
                                                         : CFG_DATA_W'($urandom_range(0, 3000));
    endfunction

    // mostly well formed readings with random content, some ticks, some line noise
    task automatic random_phase(input int unsigned n);
        int unsigned     first;
        int unsigned     r;
        int              v;
        logic [RX_W-1:0] tag;
        logic [RX_W-1:0] c;
        first = beats_sent;
        while (beats_sent - first < n) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                r = $urandom_range(0, 2);
                tag = (r == 0) ? CH_Q : ((r == 1) ? CH_J : CH_W);
                r = $urandom_range(0, 9);
                if (tag == CH_J && r < 5)
                    v = int'(sb.vmin) + int'($urandom_range(0, 60)) - 30;
                else if (r < 7)
                    v = $urandom_range(0, 1023);
                else if (r < 9)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else
                    v = int'($urandom_range(0, 999999)) * ($urandom_range(0, 1) ? 1 : -1);
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
                    r = $urandom_range(0, 5);
                    send_beat(CMD_BYTE, (r == 5) ? CH_SPACE : CH_TAB + RX_W'(r));
                end
                if (v < 0)
                    send_beat(CMD_BYTE, CH_MINUS);
                else if ($urandom_range(0, 3) == 0)
                    send_beat(CMD_BYTE, CH_PLUS);
                if ($urandom_range(0, 7) == 0)
                    send_beat(CMD_BYTE, CH_0);
                send_digits((v < 0) ? -v : v);
                if ($urandom_range(0, 9) == 0) begin
                    do c = RX_W'($urandom); while (c == CH_Q || c == CH_J || c == CH_W);
                    send_beat(CMD_BYTE, c);
                end
                send_beat(CMD_BYTE, tag);
            end else if (r < 88) begin
                send_beat(CMD_TICK, RX_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) send_beat(CMD_BYTE, RX_W'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed beats on the reset settings
        send_beat(CMD_BYTE, CH_CR);
        send_beat(CMD_BYTE, CH_MINUS);
        send_digits(12);
        send_beat(CMD_BYTE, CH_Q);
        send_beat(CMD_TICK, 8'h00);
        send_digits(40000);
        send_beat(CMD_BYTE, CH_J);
        send_beat(CMD_TICK, 8'hFF);
        send_beat(CMD_BYTE, CH_MINUS);
        send_digits(99999);
        send_beat(CMD_BYTE, CH_W);
        // sign after sign is malformed and latches zero, as does a bare tag
        send_beat(CMD_BYTE, CH_MINUS);
        send_beat(CMD_BYTE, CH_PLUS);
        send_digits(5);
        send_beat(CMD_BYTE, CH_Q);
        send_beat(CMD_BYTE, CH_W);
        drain();

        set_defaults();
        load_config();
        random_phase(140);
        drain();

        // widest values, upper data bits set beyond every register narrower than the port
        foreach (cfg_vals[i])
            cfg_vals[i] = '1;
        cfg_vals[REG_VMIN] = 20'hF7FFF;
        load_config();
        random_phase(60);
        drain();

        // zero sensitivity and bottom resistor, lowest threshold
        foreach (cfg_vals[i])
            cfg_vals[i] = '0;
        cfg_vals[REG_VMIN] = 20'h08000;
        load_config();
        random_phase(60);
        drain();

        // good voltage first, then a dropout long enough to saturate the count
        set_defaults();
        load_config();
        send_digits(3000);
        send_beat(CMD_BYTE, CH_J);
        send_ticks(1);
        drain();
        cfg_vals[REG_DROP] = 20'd254;
        cfg_vals[REG_VMIN] = 20'h07FFF;
        load_config();
        send_ticks(260);
        drain();

        repeat (3) begin
            random_config();
            load_config();
            random_phase(100);
            drain();
        end

        foreach (cfg_vals[i])
            cfg_vals[i] = CFG_DATA_W'($urandom);
        load_config();
        random_phase(60);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d byte beats and %0d tick beats under %0d register loads",
                 sb.bytes_seen, sb.ticks_seen, cfg_loads + 1);
        $display("%0d output beats checked, %0d mismatches, %0d readings outstanding",
                 sb.results, sb.errors, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
